FILE: sv/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// shared types, protocol byte codes and crc helper for the xmodem crc receiver
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CA  = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [7:0]  SEQ_INV_MASK = 8'hff;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [10:0] LEN_SMALL    = 11'd128;
  localparam logic [10:0] LEN_BIG      = 11'd1024;
  localparam logic [23:0] IDLE_MAX     = 24'hffffff;
  localparam logic [7:0]  ERR_MAX      = 8'hff;

  // input kinds
  localparam logic [2:0] K_BYTE     = 3'd0;
  localparam logic [2:0] K_TICK     = 3'd1;
  localparam logic [2:0] K_FLASH_OK = 3'd2;
  localparam logic [2:0] K_FLASH_NG = 3'd3;
  localparam logic [2:0] K_START    = 3'd4;

  // session end status
  localparam logic [1:0] ST_EOT    = 2'd0;
  localparam logic [1:0] ST_CANCEL = 2'd1;
  localparam logic [1:0] ST_ERRORS = 2'd2;
  localparam logic [1:0] ST_FLASH  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_ERRLIM  = 2'd1;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        commit_valid;
    logic [10:0] commit_length;
    logic [23:0] commit_offset;
    logic        discard;
    logic        finished;
    logic [1:0]  status;
  } res_t;

  // one queue entry: the first result plus an optional trailing CA that ends the session
  typedef struct packed {
    res_t       first;
    logic       two;
    logic [1:0] second_status;
  } desc_t;

  localparam res_t RES_NONE = '0;

  function automatic res_t make_tx(input logic [7:0] b, input logic fin,
                                   input logic [1:0] st, input logic disc);
    res_t r;
    r          = RES_NONE;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.discard  = disc;
    r.finished = fin;
    r.status   = fin ? st : ST_EOT;
    return r;
  endfunction

  // crc-16/xmodem, one byte, msb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: sv/xcr_front.sv
// ----------------------------------------------------------------------------
// xcr_front
// protocol engine: classifies each transaction, updates session state and
// pushes the results it causes into the queue
// ----------------------------------------------------------------------------
module xcr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              in_fire,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_rx_byte,
  output logic              push,
  output xcr_pkg::desc_t    push_desc
);

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_HDR   = 10'b00_0000_0010,
    PH_CA2   = 10'b00_0000_0100,
    PH_SEQ   = 10'b00_0000_1000,
    PH_SEQC  = 10'b00_0001_0000,
    PH_DATA  = 10'b00_0010_0000,
    PH_CRCH  = 10'b00_0100_0000,
    PH_CRCL  = 10'b00_1000_0000,
    PH_FLASH = 10'b01_0000_0000,
    PH_DONE  = 10'b10_0000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        big_r, big_nxt;
  logic [10:0] byte_count_r, byte_count_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  seqc_r, seqc_nxt;
  logic [7:0]  exp_seq_r, exp_seq_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [7:0]  err_r, err_nxt;
  logic        begun_r, begun_nxt;
  logic [23:0] idle_r, idle_nxt;
  logic [23:0] offset_r, offset_nxt;
  logic [23:0] timeout_r;
  logic [7:0]  limit_r;

  logic [10:0] len;
  logic [10:0] count_inc;
  logic [23:0] idle_inc;
  logic [23:0] lim;
  logic [7:0]  err_inc;
  logic        emit;
  logic        active;
  xcr_pkg::desc_t d;

  assign len       = big_r ? xcr_pkg::LEN_BIG : xcr_pkg::LEN_SMALL;
  assign count_inc = byte_count_r + 11'd1;
  assign idle_inc  = (idle_r == xcr_pkg::IDLE_MAX) ? idle_r : idle_r + 24'd1;
  assign lim       = (timeout_r == 24'd0) ? 24'd1 : timeout_r;
  assign err_inc   = (begun_r && err_r != xcr_pkg::ERR_MAX) ? err_r + 8'd1 : err_r;
  assign active    = (phase_r != PH_IDLE) && (phase_r != PH_FLASH) && (phase_r != PH_DONE);

  always_comb begin
    phase_nxt      = phase_r;
    big_nxt        = big_r;
    byte_count_nxt = byte_count_r;
    seq_nxt        = seq_r;
    seqc_nxt       = seqc_r;
    exp_seq_nxt    = exp_seq_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    err_nxt        = err_r;
    begun_nxt      = begun_r;
    idle_nxt       = idle_r;
    offset_nxt     = offset_r;
    emit           = 1'b0;
    d              = '0;

    if (in_kind == xcr_pkg::K_START) begin
      phase_nxt      = PH_HDR;
      big_nxt        = 1'b0;
      byte_count_nxt = '0;
      crc_nxt        = '0;
      exp_seq_nxt    = 8'd1;
      err_nxt        = '0;
      begun_nxt      = 1'b0;
      idle_nxt       = '0;
      offset_nxt     = '0;
    end else if (active) begin
      logic take_error;
      logic err_disc;
      take_error = 1'b0;
      err_disc   = 1'b0;
      if (in_kind == xcr_pkg::K_BYTE) begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_HDR: begin
            priority if (in_rx_byte == xcr_pkg::B_SOH || in_rx_byte == xcr_pkg::B_STX) begin
              big_nxt        = (in_rx_byte == xcr_pkg::B_STX);
              byte_count_nxt = '0;
              crc_nxt        = '0;
              phase_nxt      = PH_SEQ;
            end else if (in_rx_byte == xcr_pkg::B_EOT) begin
              err_nxt        = '0;
              emit           = 1'b1;
              d.first        = xcr_pkg::make_tx(xcr_pkg::B_ACK, 1'b1, xcr_pkg::ST_EOT, 1'b0);
              phase_nxt      = PH_DONE;
              byte_count_nxt = '0;
            end else if (in_rx_byte == xcr_pkg::B_CA) begin
              phase_nxt = PH_CA2;
            end else begin
              take_error = 1'b1;
            end
          end
          PH_CA2: begin
            if (in_rx_byte == xcr_pkg::B_CA) begin
              err_nxt        = '0;
              emit           = 1'b1;
              d.first        = xcr_pkg::make_tx(xcr_pkg::B_ACK, 1'b1, xcr_pkg::ST_CANCEL, 1'b0);
              phase_nxt      = PH_DONE;
              byte_count_nxt = '0;
            end else begin
              take_error = 1'b1;
            end
          end
          PH_SEQ: begin
            seq_nxt   = in_rx_byte;
            phase_nxt = PH_SEQC;
          end
          PH_SEQC: begin
            seqc_nxt  = in_rx_byte;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            emit                    = 1'b1;
            d.first.payload_valid   = 1'b1;
            d.first.payload_byte    = in_rx_byte;
            d.first.payload_index   = byte_count_r[9:0];
            crc_nxt                 = xcr_pkg::crc_update(crc_r, in_rx_byte);
            byte_count_nxt          = count_inc;
            if (count_inc >= len) begin
              phase_nxt = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crc_hi_nxt = in_rx_byte;
            phase_nxt  = PH_CRCL;
          end
          PH_CRCL: begin
            priority if (seq_r != (seqc_r ^ xcr_pkg::SEQ_INV_MASK) ||
                         {crc_hi_r, in_rx_byte} != crc_r) begin
              take_error = 1'b1;
              err_disc   = 1'b1;
            end else if (seq_r != exp_seq_r) begin
              err_nxt        = '0;
              phase_nxt      = PH_HDR;
              byte_count_nxt = '0;
              emit           = 1'b1;
              d.first        = xcr_pkg::make_tx(xcr_pkg::B_NAK, 1'b0, xcr_pkg::ST_EOT, 1'b1);
            end else begin
              err_nxt               = '0;
              emit                  = 1'b1;
              d.first.commit_valid  = 1'b1;
              d.first.commit_length = len;
              d.first.commit_offset = offset_r;
              phase_nxt             = PH_FLASH;
            end
          end
          default: begin
          end
        endcase
      end else if (in_kind == xcr_pkg::K_TICK) begin
        idle_nxt = idle_inc;
        if (idle_inc >= lim) begin
          take_error = 1'b1;
          err_disc   = (phase_r != PH_HDR) && (phase_r != PH_CA2);
        end
      end

      if (take_error) begin
        byte_count_nxt = '0;
        idle_nxt       = '0;
        err_nxt        = err_inc;
        emit           = 1'b1;
        if (err_inc > limit_r) begin
          d.first         = xcr_pkg::make_tx(xcr_pkg::B_CA, 1'b0, xcr_pkg::ST_EOT, err_disc);
          d.two           = 1'b1;
          d.second_status = xcr_pkg::ST_ERRORS;
          phase_nxt       = PH_DONE;
        end else begin
          d.first   = xcr_pkg::make_tx(xcr_pkg::B_C, 1'b0, xcr_pkg::ST_EOT, err_disc);
          phase_nxt = PH_HDR;
        end
      end
    end else if (phase_r == PH_FLASH) begin
      if (in_kind == xcr_pkg::K_FLASH_OK) begin
        emit           = 1'b1;
        d.first        = xcr_pkg::make_tx(xcr_pkg::B_ACK, 1'b0, xcr_pkg::ST_EOT, 1'b0);
        offset_nxt     = offset_r + {13'd0, len};
        exp_seq_nxt    = exp_seq_r + 8'd1;
        begun_nxt      = 1'b1;
        err_nxt        = '0;
        phase_nxt      = PH_HDR;
        byte_count_nxt = '0;
        idle_nxt       = '0;
      end else if (in_kind == xcr_pkg::K_FLASH_NG) begin
        emit            = 1'b1;
        d.first         = xcr_pkg::make_tx(xcr_pkg::B_CA, 1'b0, xcr_pkg::ST_EOT, 1'b0);
        d.two           = 1'b1;
        d.second_status = xcr_pkg::ST_FLASH;
        phase_nxt       = PH_DONE;
        byte_count_nxt  = '0;
        idle_nxt        = '0;
      end
    end
  end

  assign push      = in_fire && emit;
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      big_r        <= 1'b0;
      byte_count_r <= '0;
      seq_r        <= '0;
      seqc_r       <= '0;
      exp_seq_r    <= 8'd1;
      crc_r        <= '0;
      crc_hi_r     <= '0;
      err_r        <= '0;
      begun_r      <= 1'b0;
      idle_r       <= '0;
      offset_r     <= '0;
      timeout_r    <= 24'd1000000;
      limit_r      <= 8'd5;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        big_r        <= big_nxt;
        byte_count_r <= byte_count_nxt;
        seq_r        <= seq_nxt;
        seqc_r       <= seqc_nxt;
        exp_seq_r    <= exp_seq_nxt;
        crc_r        <= crc_nxt;
        crc_hi_r     <= crc_hi_nxt;
        err_r        <= err_nxt;
        begun_r      <= begun_nxt;
        idle_r       <= idle_nxt;
        offset_r     <= offset_nxt;
      end
      if (cfg_wr_en) begin
        if (cfg_index == xcr_pkg::CFG_TIMEOUT) begin
          timeout_r <= cfg_data;
        end else if (cfg_index == xcr_pkg::CFG_ERRLIM) begin
          limit_r <= cfg_data[7:0];
        end
      end
    end
  end

endmodule

FILE: sv/xcr_queue.sv
// ----------------------------------------------------------------------------
// xcr_queue
// small fifo of result descriptors between the protocol engine and the
// output stage
// ----------------------------------------------------------------------------
module xcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xcr_pkg::desc_t push_desc,
  input  logic           pop,
  output xcr_pkg::desc_t pop_desc,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  xcr_pkg::desc_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);
  assign pop_desc = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: sv/xcr_back.sv
// ----------------------------------------------------------------------------
// xcr_back
// output stage: expands queued descriptors into one or two results and holds
// each in the output register until its transaction completes
// ----------------------------------------------------------------------------
module xcr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  xcr_pkg::desc_t q_desc,
  output logic           q_pop,
  input  logic           out_ready,
  output logic           out_valid,
  output xcr_pkg::res_t  out_res,
  output logic           out_last
);

  logic          valid_r;
  logic          pend_r;
  logic [1:0]    pend_status_r;
  xcr_pkg::res_t res_r;
  logic          last_r;
  logic          load;

  assign load      = !valid_r || out_ready;
  assign q_pop     = load && !pend_r && !q_empty;
  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
      end else begin
        valid_r <= !q_empty;
        pend_r  <= !q_empty && q_desc.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        res_r  <= xcr_pkg::make_tx(xcr_pkg::B_CA, 1'b1, pend_status_r, 1'b0);
        last_r <= 1'b1;
      end else begin
        res_r         <= q_desc.first;
        last_r        <= !q_desc.two;
        pend_status_r <= q_desc.second_status;
      end
    end
  end

endmodule

FILE: sv/xmodem_crc_receiver_top.sv
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_top
// xmodem-crc / xmodem-1k receiver with streaming payload and commit output
// ----------------------------------------------------------------------------
// One input transaction (received byte, tick, flash outcome or session start)
// is accepted every cycle while the result queue of QUEUE_DEPTH entries has
// room; the protocol engine updates framing, sequence and crc state in that
// same cycle. The output register delivers one result per cycle while
// out_ready is high, so an event that ends a session with CA CA yields two
// results and everything else at most one. Each result passes through the
// queue and then the output register before it reaches the output.
module xmodem_crc_receiver_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [9:0]  out_payload_index,
  output logic        out_commit_valid,
  output logic [10:0] out_commit_length,
  output logic [23:0] out_commit_offset,
  output logic        out_discard,
  output logic        out_finished,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic           q_full, q_empty, q_push, q_pop;
  xcr_pkg::desc_t push_desc, pop_desc;
  xcr_pkg::res_t  res;

  assign in_ready = !q_full;

  xcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_valid && in_ready),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .push       (q_push),
    .push_desc  (push_desc)
  );

  xcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .empty     (q_empty),
    .full      (q_full)
  );

  xcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (pop_desc),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_tx_valid      = res.tx_valid;
  assign out_tx_byte       = res.tx_byte;
  assign out_payload_valid = res.payload_valid;
  assign out_payload_byte  = res.payload_byte;
  assign out_payload_index = res.payload_index;
  assign out_commit_valid  = res.commit_valid;
  assign out_commit_length = res.commit_length;
  assign out_commit_offset = res.commit_offset;
  assign out_discard       = res.discard;
  assign out_finished      = res.finished;
  assign out_status        = res.status;

endmodule

FILE: sv/xcr_checker.sv
// ----------------------------------------------------------------------------
// xcr_checker
// port-level checks on the result stream of the xmodem crc receiver
// ----------------------------------------------------------------------------
module xcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_byte,
  input logic        out_payload_valid,
  input logic        out_commit_valid,
  input logic [10:0] out_commit_length,
  input logic        out_finished,
  input logic        out_last
);

  // session end always rides on a reply byte and closes the transaction group
  a_finish_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_tx_valid && out_last)
    else $error("finished without reply byte or not last");

  // a payload byte is a result of its own
  a_payload_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> !out_tx_valid && !out_commit_valid && out_last)
    else $error("payload result mixed with other fields");

  a_commit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_commit_valid |-> (out_commit_length == xcr_pkg::LEN_SMALL ||
                                       out_commit_length == xcr_pkg::LEN_BIG))
    else $error("bad commit length");

  // only a cancel pair spans two results, and its second half ends the session
  a_pair_is_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_tx_valid && out_tx_byte == xcr_pkg::B_CA && out_finished)
    else $error("two-result group is not a cancel pair");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind xmodem_crc_receiver_top xcr_checker u_xcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_tx_valid      (out_tx_valid),
  .out_tx_byte       (out_tx_byte),
  .out_payload_valid (out_payload_valid),
  .out_commit_valid  (out_commit_valid),
  .out_commit_length (out_commit_length),
  .out_finished      (out_finished),
  .out_last          (out_last)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the xmodem crc receiver. A driver and a monitor
// exchange transactions with the block on random sender bursts and receiver
// stalls. Every accepted event runs through an independent protocol
// predictor, and each result is compared in order with its prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xcr_pkg::*;

  localparam logic [2:0] K_UNDEF_LO = 3'd5;
  localparam logic [2:0] K_UNDEF_HI = 3'd7;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [3:0] {
    RX_IDLE, RX_HDR, RX_CA2, RX_SEQ, RX_SEQC, RX_DATA, RX_CRCH, RX_CRCL, RX_FLASH, RX_DONE
  } rx_phase_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PATTERN} ready_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } rx_event_t;

  typedef struct packed {
    res_t res;
    logic last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_TIMEOUT;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = K_BYTE;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_tx_valid;
  logic [7:0] out_tx_byte;
  logic out_payload_valid;
  logic [7:0] out_payload_byte;
  logic [9:0] out_payload_index;
  logic out_commit_valid;
  logic [10:0] out_commit_length;
  logic [23:0] out_commit_offset;
  logic out_discard;
  logic out_finished;
  logic [1:0] out_status;
  logic out_last;

  xmodem_crc_receiver_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver model state and its copy of the registers
  rx_phase_t ph = RX_IDLE;
  logic big_pkt = 1'b0;
  logic [10:0] data_cnt = '0;
  logic [7:0] seq_got = '0, seq_inv = '0, want_seq = 8'd1;
  logic [15:0] crc_acc = '0, crc_got = '0;
  logic [7:0] err_cnt = '0;
  logic begun = 1'b0;
  logic [23:0] idle_cnt = '0, image_pos = '0;
  logic [23:0] tmo_cfg = 24'd1000000;
  logic [7:0] lim_cfg = 8'd5;

  res_t step_out[$];
  reply_t reply_q[$];
  rx_event_t event_q[$];

  // stimulus side bookkeeping
  int made_count = 0;
  logic [7:0] g_seq = 8'd1;
  logic g_begun = 1'b0;
  logic [7:0] g_errs = '0;

  int fail_count = 0;
  int burst_left = 1, gap_left = 0;
  rx_event_t next_ev;
  ready_mode_t stall_mode = RDY_ALWAYS;
  int hold_left = 0, pattern_cnt = 0;
  int quiet_cycles = 0;
  reply_t got_r, want_r;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] s;
    logic fb;
    s = c;
    for (int k = 7; k >= 0; k--) begin
      fb = s[15] ^ d[k];
      s = {s[14:0], 1'b0};
      if (fb) s = s ^ CRC_POLY;
    end
    return s;
  endfunction

  // zero in the timeout register acts as one tick
  function automatic logic [23:0] timeout_limit();
    return (tmo_cfg == '0) ? 24'd1 : tmo_cfg;
  endfunction

  function automatic string show(input reply_t x);
    return $sformatf("tx %b/%h pay %b/%h/%0d commit %b/%0d/%h disc %b fin %b st %0d last %b",
                     x.res.tx_valid, x.res.tx_byte, x.res.payload_valid, x.res.payload_byte,
                     x.res.payload_index, x.res.commit_valid, x.res.commit_length,
                     x.res.commit_offset, x.res.discard, x.res.finished, x.res.status, x.last);
  endfunction

  task automatic stage_tx(input logic [7:0] b, input logic fin, input logic [1:0] st,
                          input logic disc);
    res_t r;
    r = RES_NONE;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    r.discard = disc;
    r.finished = fin;
    r.status = fin ? st : ST_EOT;
    step_out.push_back(r);
  endtask

  task automatic close_session();
    ph = RX_DONE;
    data_cnt = '0;
    idle_cnt = '0;
  endtask

  task automatic take_error(input logic disc);
    ph = RX_HDR;
    data_cnt = '0;
    idle_cnt = '0;
    if (begun && err_cnt != ERR_MAX) err_cnt++;
    if (err_cnt > lim_cfg) begin
      stage_tx(B_CA, 1'b0, ST_EOT, disc);
      stage_tx(B_CA, 1'b1, ST_ERRORS, 1'b0);
      close_session();
    end else begin
      stage_tx(B_C, 1'b0, ST_EOT, disc);
    end
  endtask

  // advances the receiver model by one event and queues the replies it causes
  task automatic xmodem_step(input logic [2:0] kind, input logic [7:0] b);
    logic [10:0] len;
    res_t r;
    reply_t rep;
    len = big_pkt ? LEN_BIG : LEN_SMALL;
    r = RES_NONE;
    step_out.delete();
    if (kind == K_START) begin
      ph = RX_HDR;
      big_pkt = 1'b0;
      data_cnt = '0;
      crc_acc = '0;
      want_seq = 8'd1;
      err_cnt = '0;
      begun = 1'b0;
      idle_cnt = '0;
      image_pos = '0;
    end else if (ph >= RX_HDR && ph <= RX_CRCL) begin
      if (kind == K_BYTE) begin
        idle_cnt = '0;
        case (ph)
          RX_HDR: begin
            if (b == B_SOH || b == B_STX) begin
              big_pkt = (b == B_STX);
              data_cnt = '0;
              crc_acc = '0;
              ph = RX_SEQ;
            end else if (b == B_EOT) begin
              err_cnt = '0;
              stage_tx(B_ACK, 1'b1, ST_EOT, 1'b0);
              close_session();
            end else if (b == B_CA) begin
              ph = RX_CA2;
            end else begin
              take_error(1'b0);
            end
          end
          RX_CA2: begin
            if (b == B_CA) begin
              err_cnt = '0;
              stage_tx(B_ACK, 1'b1, ST_CANCEL, 1'b0);
              close_session();
            end else begin
              take_error(1'b0);
            end
          end
          RX_SEQ: begin
            seq_got = b;
            ph = RX_SEQC;
          end
          RX_SEQC: begin
            seq_inv = b;
            ph = RX_DATA;
          end
          RX_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = data_cnt[9:0];
            step_out.push_back(r);
            crc_acc = crc16_byte(crc_acc, b);
            data_cnt = data_cnt + 11'd1;
            if (data_cnt >= len) ph = RX_CRCH;
          end
          RX_CRCH: begin
            crc_got = {b, 8'h00};
            ph = RX_CRCL;
          end
          RX_CRCL: begin
            crc_got[7:0] = b;
            if (seq_got != (seq_inv ^ SEQ_INV_MASK) || crc_got != crc_acc) begin
              take_error(1'b1);
            end else if (seq_got != want_seq) begin
              err_cnt = '0;
              ph = RX_HDR;
              data_cnt = '0;
              stage_tx(B_NAK, 1'b0, ST_EOT, 1'b1);
            end else begin
              err_cnt = '0;
              r.commit_valid = 1'b1;
              r.commit_length = len;
              r.commit_offset = image_pos;
              step_out.push_back(r);
              ph = RX_FLASH;
            end
          end
          default: ;
        endcase
      end else if (kind == K_TICK) begin
        if (idle_cnt != IDLE_MAX) idle_cnt++;
        if (idle_cnt >= timeout_limit()) take_error(ph >= RX_SEQ);
      end
    end else if (ph == RX_FLASH) begin
      if (kind == K_FLASH_OK) begin
        stage_tx(B_ACK, 1'b0, ST_EOT, 1'b0);
        image_pos = image_pos + {13'd0, len};
        want_seq = want_seq + 8'd1;
        begun = 1'b1;
        err_cnt = '0;
        ph = RX_HDR;
        data_cnt = '0;
        idle_cnt = '0;
      end else if (kind == K_FLASH_NG) begin
        stage_tx(B_CA, 1'b0, ST_EOT, 1'b0);
        stage_tx(B_CA, 1'b1, ST_FLASH, 1'b0);
        close_session();
      end
    end
    foreach (step_out[i]) begin
      rep.res = step_out[i];
      rep.last = (i == step_out.size() - 1);
      reply_q.push_back(rep);
    end
  endtask

  // ---- stimulus helpers ----

  task automatic put(input logic [2:0] kind, input logic [7:0] data);
    rx_event_t e;
    e.kind = kind;
    e.data = data;
    event_q.push_back(e);
    made_count++;
  endtask

  task automatic restart_session();
    put(K_START, 8'($urandom_range(0, 255)));
    g_seq = 8'd1;
    g_begun = 1'b0;
    g_errs = '0;
  endtask

  // rough tracking of the error count so that sessions ended by errors restart
  task automatic gen_fault();
    if (g_begun && g_errs != ERR_MAX) g_errs++;
    if (g_errs > lim_cfg) restart_session();
  endtask

  task automatic send_packet(input logic big, input logic [7:0] seq_no,
                             input logic [7:0] seq_cpl, input logic [15:0] crc_flip,
                             input int cut);
    logic [15:0] crc;
    logic [7:0] b;
    int len;
    len = big ? int'(LEN_BIG) : int'(LEN_SMALL);
    crc = '0;
    put(K_BYTE, big ? B_STX : B_SOH);
    put(K_BYTE, seq_no);
    put(K_BYTE, seq_cpl);
    for (int i = 0; i < len && i < cut; i++) begin
      case ($urandom_range(0, 15))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      crc = crc16_byte(crc, b);
      put(K_BYTE, b);
    end
    if (cut >= len) begin
      crc = crc ^ crc_flip;
      put(K_BYTE, crc[15:8]);
      put(K_BYTE, crc[7:0]);
    end
  endtask

  // mostly well-formed transfers, with damaged packets, stalls and noise mixed in
  task automatic random_traffic(input int n);
    int stop, sel;
    logic big;
    logic [7:0] bad, b;
    logic [23:0] tlim;
    stop = made_count + n;
    restart_session();
    while (made_count < stop) begin
      sel = $urandom_range(0, 99);
      // a whole packet only while the remaining event budget still holds one
      if (stop - made_count < 140) sel = $urandom_range(72, 99);
      big = ($urandom_range(0, 3) == 0);
      tlim = timeout_limit();
      if (sel < 45) begin
        send_packet(1'b0, g_seq, ~g_seq, 16'h0000, int'(LEN_SMALL));
        // bytes and ticks while the flash write is pending are dropped
        repeat ($urandom_range(0, 2))
          put($urandom_range(0, 1) ? K_TICK : K_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) begin
          put(K_FLASH_OK, 8'($urandom_range(0, 255)));
          g_seq = g_seq + 8'd1;
          g_begun = 1'b1;
          g_errs = '0;
        end else begin
          put(K_FLASH_NG, 8'($urandom_range(0, 255)));
          restart_session();
        end
      end else if (sel < 55) begin
        bad = $urandom_range(0, 1) ? g_seq - 8'd1 : 8'($urandom_range(0, 255));
        if (bad == g_seq) bad = bad ^ 8'h80;
        send_packet(1'b0, bad, ~bad, 16'h0000, int'(LEN_SMALL));
        g_errs = '0;
      end else if (sel < 65) begin
        if ($urandom_range(0, 1))
          send_packet(1'b0, g_seq, ~g_seq ^ (8'h01 << $urandom_range(0, 7)), 16'h0000,
                      int'(LEN_SMALL));
        else
          send_packet(1'b0, g_seq, ~g_seq, 16'h0001 << $urandom_range(0, 15),
                      int'(LEN_SMALL));
        gen_fault();
      end else if (sel < 72) begin
        send_packet(big, g_seq, ~g_seq, 16'h0000, $urandom_range(0, 127));
        if (tlim <= 24'd64) begin
          repeat (tlim) put(K_TICK, 8'($urandom_range(0, 255)));
          gen_fault();
        end else begin
          restart_session();
        end
      end else if (sel < 78) begin
        do b = 8'($urandom_range(0, 255));
        while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CA);
        put(K_BYTE, b);
        gen_fault();
      end else if (sel < 82) begin
        do b = 8'($urandom_range(0, 255));
        while (b == B_CA);
        put(K_BYTE, B_CA);
        put(K_BYTE, b);
        gen_fault();
      end else if (sel < 85) begin
        put(K_BYTE, B_CA);
        if (tlim <= 24'd64) begin
          repeat (tlim) put(K_TICK, 8'($urandom_range(0, 255)));
          gen_fault();
        end else begin
          put(K_BYTE, B_CA);
          restart_session();
        end
      end else if (sel < 90) begin
        repeat ($urandom_range(1, (tlim <= 24'd64) ? tlim : 8))
          put(K_TICK, 8'($urandom_range(0, 255)));
      end else if (sel < 94) begin
        put(K_BYTE, B_EOT);
        restart_session();
      end else if (sel < 97) begin
        put(K_BYTE, B_CA);
        put(K_BYTE, B_CA);
        restart_session();
      end else begin
        case ($urandom_range(0, 2))
          0: put(3'($urandom_range(K_UNDEF_LO, K_UNDEF_HI)), 8'($urandom_range(0, 255)));
          1: put($urandom_range(0, 1) ? K_FLASH_OK : K_FLASH_NG, 8'($urandom_range(0, 255)));
          default: begin
            send_packet(1'b0, g_seq, ~g_seq, 16'h0000, $urandom_range(0, 20));
            restart_session();
          end
        endcase
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (event_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TIMEOUT) tmo_cfg = val;
    else lim_cfg = val[7:0];
  endtask

  // ---- driver: bursts of transactions separated by random gaps ----
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) xmodem_step(in_kind, in_rx_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          next_ev = event_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_ev.kind;
          in_rx_byte <= next_ev.data;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 48);
            case ($urandom_range(0, 3))
              0, 1: gap_left <= 0;
              2: gap_left <= $urandom_range(1, 3);
              default: gap_left <= $urandom_range(4, 12);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result side: stall mode is redrawn whenever its hold count runs out ----
  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 1;
    if (hold_left == 0) begin
      stall_mode <= ready_mode_t'($urandom_range(0, 3));
      hold_left <= $urandom_range(20, 300);
    end else begin
      hold_left <= hold_left - 1;
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (pattern_cnt % 5 < 2);
    endcase
  end

  // ---- monitor ----
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_r.res.tx_valid = out_tx_valid;
      got_r.res.tx_byte = out_tx_byte;
      got_r.res.payload_valid = out_payload_valid;
      got_r.res.payload_byte = out_payload_byte;
      got_r.res.payload_index = out_payload_index;
      got_r.res.commit_valid = out_commit_valid;
      got_r.res.commit_length = out_commit_length;
      got_r.res.commit_offset = out_commit_offset;
      got_r.res.discard = out_discard;
      got_r.res.finished = out_finished;
      got_r.res.status = out_status;
      got_r.last = out_last;
      if (reply_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected transaction: %s", show(got_r));
        fail_count++;
      end else begin
        want_r = reply_q.pop_front();
        if (got_r !== want_r) begin
          if (fail_count < 10) begin
            $display("mismatch: expected %s", show(want_r));
            $display("          actual   %s", show(got_r));
          end
          fail_count++;
        end
      end
    end
  end

  // ---- watchdog on cycles without any transaction ----
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_TIMEOUT, 24'd1);
    cfg_write(CFG_ERRLIM, 24'd0);

    // events before any session are dropped
    put(K_FLASH_OK, 8'h00);
    put(K_BYTE, B_EOT);
    put(K_TICK, 8'h00);
    for (k = K_UNDEF_LO; k <= K_UNDEF_HI; k++) put(k[2:0], 8'ha5);
    put(K_START, 8'hff);
    // junk headers, a tick timeout, lone CA by byte and by timeout
    put(K_BYTE, 8'h00);
    put(K_BYTE, 8'hff);
    put(K_TICK, 8'h00);
    put(K_BYTE, B_CA);
    put(K_BYTE, 8'h55);
    put(K_BYTE, B_CA);
    put(K_TICK, 8'h00);
    // timeouts inside a packet discard it
    put(K_BYTE, B_SOH);
    put(K_BYTE, 8'h01);
    put(K_BYTE, 8'hfe);
    put(K_TICK, 8'h00);
    put(K_FLASH_NG, 8'h00);
    put(K_BYTE, B_STX);
    put(K_TICK, 8'h00);
    // sender cancel, then nothing happens until a new start
    put(K_BYTE, B_CA);
    put(K_BYTE, B_CA);
    put(K_BYTE, B_SOH);
    put(K_TICK, 8'h00);
    put(K_FLASH_OK, 8'h00);
    put(K_START, 8'h00);
    put(K_BYTE, B_EOT);
    random_traffic(150);
    wait_quiet();

    cfg_write(CFG_TIMEOUT, 24'd4);
    cfg_write(CFG_ERRLIM, 24'd3);
    random_traffic(150);
    wait_quiet();

    cfg_write(CFG_TIMEOUT, IDLE_MAX);
    cfg_write(CFG_ERRLIM, {16'h0000, ERR_MAX});
    random_traffic(30);
    wait_quiet();

    cfg_write(CFG_TIMEOUT, 24'd0);
    cfg_write(CFG_ERRLIM, 24'd1);
    random_traffic(30);
    wait_quiet();

    cfg_write(CFG_TIMEOUT, 24'($urandom_range(2, 40)));
    cfg_write(CFG_ERRLIM, 24'($urandom_range(0, 6)));
    random_traffic(40);
    wait_quiet();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
